### src/pts_pkg.sv
// shared constants, command and status codes for the priority task scheduler
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;

   // default sizing
   localparam int PTS_LEVELS      = 8;
   localparam int PTS_LEVEL_DEPTH = 16;
   localparam int PTS_TAG_BITS    = 16;

   // fixed field widths on the streams
   localparam int REQ_TAG_W  = 16;
   localparam int PRIO_W     = 3;
   localparam int STATUS_W   = 2;
   localparam int WAIT_W     = 8;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   typedef enum logic [0:0] {
      CMD_ADD    = 1'b0,
      CMD_CHOOSE = 1'b1
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

endpackage
`default_nettype wire

### src/pts_tag_ram.sv
// single-port tag memory with a registered read
`timescale 1ns / 1ps
`default_nettype none
module pts_tag_ram
   import pts_pkg::*;
#(
   parameter int DEPTH  = PTS_LEVELS * PTS_LEVEL_DEPTH,
   parameter int ADDR_W = 7,
   parameter int DATA_W = PTS_TAG_BITS
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
   end

   // read data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### src/priority_task_scheduler_top.sv
// priority task scheduler: per-level tag stacks in one ram, highest level served first
//
// req channel: one command per transaction. req_tuser[0] is the command (add or choose),
// req_tdata carries the task tag and its priority level. rsp channel: one result per
// command with a status in rsp_tuser and the chosen tag, its level and the number of
// tasks still waiting in rsp_tdata.
// an add pushes the tag onto its level's stack, or reports full if that level is at
// depth. a choose pops the newest tag of the highest non-empty level, or reports empty.
// levels at or above LEVELS are folded onto the top level.
// an accepted command passes through the read stage (pend registers and the tag ram's
// registered read) into the result register. no new command is taken before the result
// is loaded, because the pop goes through the read of the single-port tag ram first.
// the result register decouples the sides: a new command is taken while a result still
// waits; if rsp_tready stays low the finished command holds in the read stage and
// req_tready stays low until the result register frees up.
// reset (synchronous, active high) empties all levels at once; the tag ram itself is
// not cleared, since a slot is only read after it was pushed.
`timescale 1ns / 1ps
`default_nettype none
module priority_task_scheduler_top
   import pts_pkg::*;
#(
   parameter int LEVELS      = PTS_LEVELS,
   parameter int LEVEL_DEPTH = PTS_LEVEL_DEPTH,
   parameter int TAG_BITS    = PTS_TAG_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // task_tag [15:0], priority_req [18:16], zero pad [23:19]
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // command [0]
   input  wire logic [0:0]            req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // chosen_tag [15:0], chosen_priority [18:16], tasks_waiting [26:19], zero pad [31:27]
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // status [1:0]
   output logic [STATUS_W-1:0]        rsp_tuser
);

   localparam int SLOTS  = LEVELS * LEVEL_DEPTH;
   localparam int LVL_W  = $clog2(LEVELS);
   localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
   localparam int ADDR_W = $clog2(SLOTS);
   localparam int CNT_W  = $clog2(SLOTS + 1);
   // one spare bit so LEVELS itself is representable in the compare
   localparam int CMP_W  = ((LVL_W > PRIO_W) ? LVL_W : PRIO_W) + 1;
   localparam int SAT_W  = (CNT_W > WAIT_W) ? CNT_W : WAIT_W;

   typedef enum logic [0:0] {
      S_IDLE = 1'b0,
      S_READ = 1'b1
   } state_type;

   state_type             state_ff, state_in;
   logic [FILL_W-1:0]     fill_ff [LEVELS];
   logic [FILL_W-1:0]     fill_in [LEVELS];
   logic [CNT_W-1:0]      count_ff, count_in;
   status_type            pend_status_ff, pend_status_in;
   logic                  pend_pop_ff, pend_pop_in;
   logic [PRIO_W-1:0]     pend_prio_ff, pend_prio_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [REQ_TAG_W-1:0]  rsp_tag_ff, rsp_tag_in;
   logic [PRIO_W-1:0]     rsp_prio_ff, rsp_prio_in;
   logic [WAIT_W-1:0]     rsp_wait_ff, rsp_wait_in;

   cmd_type               req_cmd;
   logic [REQ_TAG_W-1:0]  req_tag;
   logic [PRIO_W-1:0]     req_prio;
   logic                  req_fire;
   logic [LVL_W-1:0]      add_lvl;
   logic [FILL_W-1:0]     add_fill;
   logic                  add_full;
   logic                  any_waiting;
   logic [LVL_W-1:0]      top_lvl;
   logic [FILL_W-1:0]     pop_fill;
   logic [ADDR_W-1:0]     add_addr;
   logic [ADDR_W-1:0]     pop_addr;
   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_addr;
   logic [TAG_BITS-1:0]   ram_rd_data;

   assign req_cmd   = cmd_type'(req_tuser[0]);
   assign req_tag   = req_tdata[REQ_TAG_W-1:0];
   assign req_prio  = req_tdata[REQ_TAG_W+PRIO_W-1:REQ_TAG_W];
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire  = req_tvalid && req_tready;

   // fold out-of-range levels onto the top level
   always_comb begin
      if (CMP_W'(req_prio) >= CMP_W'(LEVELS)) begin
         add_lvl = LVL_W'(LEVELS - 1);
      end else begin
         add_lvl = LVL_W'(req_prio);
      end
   end

   assign add_fill = fill_ff[add_lvl];
   assign add_full = (add_fill == FILL_W'(LEVEL_DEPTH));
   assign add_addr = ADDR_W'(add_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(add_fill);

   // highest non-empty level
   always_comb begin
      any_waiting = 1'b0;
      top_lvl     = '0;
      for (int k = 0; k < LEVELS; k++) begin
         if (fill_ff[k] != '0) begin
            any_waiting = 1'b1;
            top_lvl     = LVL_W'(k);
         end
      end
   end

   assign pop_fill = fill_ff[top_lvl] - FILL_W'(1);
   assign pop_addr = ADDR_W'(top_lvl) * ADDR_W'(LEVEL_DEPTH) + ADDR_W'(pop_fill);

   always_comb begin
      state_in       = state_ff;
      fill_in        = fill_ff;
      count_in       = count_ff;
      pend_status_in = pend_status_ff;
      pend_pop_in    = pend_pop_ff;
      pend_prio_in   = pend_prio_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      rsp_status_in  = rsp_status_ff;
      rsp_tag_in     = rsp_tag_ff;
      rsp_prio_in    = rsp_prio_ff;
      rsp_wait_in    = rsp_wait_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_addr       = add_addr;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in     = S_READ;
               pend_pop_in  = 1'b0;
               pend_prio_in = '0;
               unique case (req_cmd)
                  CMD_ADD: begin
                     if (add_full) begin
                        pend_status_in = ST_FULL;
                     end else begin
                        pend_status_in   = ST_OK;
                        ram_wr_en        = 1'b1;
                        fill_in[add_lvl] = add_fill + FILL_W'(1);
                        count_in         = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_CHOOSE: begin
                     if (any_waiting) begin
                        pend_status_in   = ST_OK;
                        pend_pop_in      = 1'b1;
                        pend_prio_in     = PRIO_W'(top_lvl);
                        ram_rd_en        = 1'b1;
                        ram_addr         = pop_addr;
                        fill_in[top_lvl] = pop_fill;
                        count_in         = count_ff - CNT_W'(1);
                     end else begin
                        pend_status_in = ST_EMPTY;
                     end
                  end
                  default: begin
                     pend_status_in = ST_EMPTY;
                  end
               endcase
            end
         end
         S_READ: begin
            // counters already hold the post-command values here
            if (!rsp_valid_ff || rsp_tready) begin
               state_in      = S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_status_in = pend_status_ff;
               rsp_tag_in    = pend_pop_ff ? REQ_TAG_W'(ram_rd_data) : '0;
               rsp_prio_in   = pend_prio_ff;
               if (SAT_W'(count_ff) > SAT_W'(255)) begin
                  rsp_wait_in = '1;
               end else begin
                  rsp_wait_in = WAIT_W'(count_ff);
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         count_ff     <= '0;
         for (int k = 0; k < LEVELS; k++) begin
            fill_ff[k] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
      end
      pend_status_ff <= pend_status_in;
      pend_pop_ff    <= pend_pop_in;
      pend_prio_ff   <= pend_prio_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_tag_ff     <= rsp_tag_in;
      rsp_prio_ff    <= rsp_prio_in;
      rsp_wait_ff    <= rsp_wait_in;
   end

   pts_tag_ram #(
      .DEPTH  (SLOTS),
      .ADDR_W (ADDR_W),
      .DATA_W (TAG_BITS)
   ) u_tag_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wr_data (TAG_BITS'(req_tag)),
      .rd_data (ram_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {
      (RSP_DATA_W - REQ_TAG_W - PRIO_W - WAIT_W)'(0),
      rsp_wait_ff,
      rsp_prio_ff,
      rsp_tag_ff
   };

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS))
      else $error("task count above capacity");

   a_accept_goes_read: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (state_ff == S_READ))
      else $error("accepted command did not enter read stage");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_ADD && !add_full)
      |=> (count_ff == CNT_W'($past(count_ff) + CNT_W'(1))))
      else $error("push did not bump task count");

   a_pop_counts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_cmd == CMD_CHOOSE && any_waiting)
      |=> (count_ff == CNT_W'($past(count_ff) - CNT_W'(1))))
      else $error("pop did not drop task count");

   a_reject_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && ((req_cmd == CMD_ADD && add_full) || (req_cmd == CMD_CHOOSE && !any_waiting)))
      |=> $stable(count_ff))
      else $error("rejected command changed task count");

endmodule
`default_nettype wire

### tb/testbench.sv
// stand-alone testbench for the priority task scheduler: per-level lifo tag stacks
`timescale 1ns / 1ps
module testbench;
   import pts_pkg::*;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int RANDOM_ITEMS   = 1300;
   localparam int QUIET_TAIL     = 150;
   localparam int LONG_HOLD      = 80;
   localparam int HOLD_AFTER     = 300;
   localparam int DRAIN_CYCLES   = 10;
   localparam int BLOCK_ITEMS    = 40;

   typedef struct {
      status_type           status;
      logic [REQ_TAG_W-1:0] tag;
      logic [PRIO_W-1:0]    level;
      logic [WAIT_W-1:0]    waiting;
   } sched_result_type;

   // tracks the scheduler contents and the results still owed by the block
   class schedule_checker;
      logic [REQ_TAG_W-1:0] level_tags [PTS_LEVELS][PTS_LEVEL_DEPTH];
      int unsigned          level_count [PTS_LEVELS];
      int unsigned          stored_total;
      sched_result_type     pending_results [$];
      int unsigned          fails, checked, n_add, n_choose, n_full, n_empty;

      function new();
         foreach (level_count[i]) level_count[i] = 0;
         stored_total = 0;
         fails = 0;
         checked = 0;
         n_add = 0;
         n_choose = 0;
         n_full = 0;
         n_empty = 0;
      endfunction

      function int unsigned pending();
         return pending_results.size();
      endfunction

      // apply one accepted command and queue the result it must produce
      function void note_command(cmd_type cmd, logic [REQ_TAG_W-1:0] tag,
                                 logic [PRIO_W-1:0] prio);
         sched_result_type r;
         int               lvl;
         r.status = ST_OK;
         r.tag    = '0;
         r.level  = '0;
         if (cmd == CMD_ADD) begin
            n_add++;
            lvl = (prio >= PTS_LEVELS) ? PTS_LEVELS - 1 : int'(prio);
            if (level_count[lvl] >= PTS_LEVEL_DEPTH) begin
               r.status = ST_FULL;
               n_full++;
            end else begin
               level_tags[lvl][level_count[lvl]] = tag;
               level_count[lvl]++;
               stored_total++;
            end
         end else begin
            n_choose++;
            r.status = ST_EMPTY;
            // highest non-empty level, newest tag first
            for (lvl = PTS_LEVELS - 1; lvl >= 0 && r.status == ST_EMPTY; lvl--) begin
               if (level_count[lvl] > 0) begin
                  level_count[lvl]--;
                  r.tag    = level_tags[lvl][level_count[lvl]];
                  r.level  = lvl[PRIO_W-1:0];
                  r.status = ST_OK;
                  stored_total--;
               end
            end
            if (r.status == ST_EMPTY) n_empty++;
         end
         r.waiting = (stored_total > 255) ? 8'hFF : stored_total[WAIT_W-1:0];
         pending_results.insert(pending_results.size(), r);
      endfunction

      function void check_field(string field, int unsigned want, int unsigned got);
         if (want != got) begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_result(logic [RSP_DATA_W-1:0] data, logic [STATUS_W-1:0] user);
         sched_result_type r;
         if (pending_results.size() == 0) begin
            fails++;
            $display("%0t: result with none expected, expected nothing, actual tdata %h tuser %h",
                     $time, data, user);
            return;
         end
         r = pending_results.pop_front();
         checked++;
         check_field("status", r.status, user);
         check_field("chosen_tag", r.tag, data[15:0]);
         check_field("chosen_priority", r.level, data[18:16]);
         check_field("tasks_waiting", r.waiting, data[26:19]);
         check_field("pad", 0, data[31:27]);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // task_tag [15:0], priority_req [18:16], zero pad [23:19]
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   // command [0]
   logic [0:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // chosen_tag [15:0], chosen_priority [18:16], tasks_waiting [26:19], zero pad [31:27]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // status [1:0]
   logic [STATUS_W-1:0]   rsp_tuser;

   schedule_checker sb;
   int unsigned     commands_sent = 0;
   int unsigned     cycle_count = 0;
   bit              quiet_tail = 1'b0;
   bit              sender_bursty = 1'b1;

   priority_task_scheduler_top u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
   end

   // result side: random stalls, one long hold-off to back the block up
   initial begin : receiver
      bit hold_done;
      hold_done = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && commands_sent >= HOLD_AFTER) begin
            hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else if (!quiet_tail && $urandom_range(0, 2) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clock);
         end
      end
   end

   task automatic send_command(cmd_type cmd, logic [REQ_TAG_W-1:0] tag,
                               logic [PRIO_W-1:0] prio);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {5'b0, prio, tag};
      do @(posedge clock); while (!req_tready);
      sb.note_command(cmd, tag, prio);
      commands_sent++;
   endtask

   task automatic sender_pause();
      if (!quiet_tail && sender_bursty && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
   endtask

   task automatic run_directed();
      send_command(CMD_CHOOSE, 16'h0000, 3'd0);
      send_command(CMD_ADD, 16'h0000, 3'd0);
      send_command(CMD_ADD, 16'hFFFF, 3'd7);
      send_command(CMD_ADD, 16'hA5A5, 3'd5);
      // tag and level of a choose are don't-care
      send_command(CMD_CHOOSE, 16'hFFFF, 3'd7);
      send_command(CMD_CHOOSE, 16'h5A5A, 3'd2);
      send_command(CMD_CHOOSE, 16'h0000, 3'd0);
      send_command(CMD_CHOOSE, 16'h1234, 3'd4);
      // fill one level to depth, then one more is rejected
      for (int i = 0; i <= PTS_LEVEL_DEPTH; i++)
         send_command(CMD_ADD, 16'h0100 + 16'(i), 3'd2);
   endtask

   task automatic run_random(int unsigned count);
      int unsigned add_pct;
      int unsigned lvl_lo;
      int unsigned lvl_hi;
      cmd_type     cmd;
      for (int unsigned i = 0; i < count; i++) begin
         if (i % BLOCK_ITEMS == 0) begin
            sender_bursty = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 2))
               0: begin
                  // pile onto one or two levels until they fill
                  add_pct = 85;
                  lvl_lo  = $urandom_range(0, PTS_LEVELS - 1);
                  lvl_hi  = (lvl_lo == PTS_LEVELS - 1) ? lvl_lo : lvl_lo + $urandom_range(0, 1);
               end
               1: begin
                  add_pct = 15;
                  lvl_lo  = 0;
                  lvl_hi  = PTS_LEVELS - 1;
               end
               default: begin
                  add_pct = 50;
                  lvl_lo  = 0;
                  lvl_hi  = PTS_LEVELS - 1;
               end
            endcase
         end
         if (i >= count - QUIET_TAIL) quiet_tail = 1'b1;
         cmd = ($urandom_range(0, 99) < add_pct) ? CMD_ADD : CMD_CHOOSE;
         send_command(cmd, 16'($urandom), 3'($urandom_range(lvl_lo, lvl_hi)));
         sender_pause();
      end
   endtask

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random(RANDOM_ITEMS);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d adds (%0d rejected on a full level), %0d chooses (%0d on empty)",
               sb.n_add, sb.n_full, sb.n_choose, sb.n_empty);
      $display("%0d results compared, %0d mismatches", sb.checked, sb.fails);
      if (sb.fails == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

### files.f
src/pts_pkg.sv
src/pts_tag_ram.sv
src/priority_task_scheduler_top.sv
tb/testbench.sv
